>>> sv/assert_macros.svh
// assertion macros shared by the pixel blend rtl
// no dependencies; include after the timescale line
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// antecedent implies consequent on the next edge, outside reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// next-edge implication that is also checked across reset
`define ASSERT_NEXT_RAW(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/pbc_pkg.sv
// types, codes and the divide-by-255 helper of the pixel blend compositor
// no dependencies; imported by every pbc module and the top level
`timescale 1ns / 1ps

package pbc_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_OPACITY = 2'd1;

    // blend mode codes; unused codes act as normal
    localparam logic [2:0] MODE_NORMAL   = 3'd0;
    localparam logic [2:0] MODE_MULTIPLY = 3'd1;
    localparam logic [2:0] MODE_SCREEN   = 3'd2;
    localparam logic [2:0] MODE_OVERLAY  = 3'd3;
    localparam logic [2:0] MODE_ADD      = 3'd4;

    localparam logic [8:0]  OPACITY_ONE = 9'd256;
    localparam logic [15:0] MIX_ONE     = 16'd65280;
    localparam logic [16:0] FULL_SQ     = 17'd65025;
    // ceil(2^26 / 255), exact floor(x/255) for x below 2^17
    localparam logic [18:0] DIV255_RECIP = 19'd263173;

    typedef struct packed {
        logic [2:0] blend_mode;
        logic [8:0] opacity;
    } pbc_cfg_t;

    // item between the blend and mix halves
    typedef struct packed {
        logic [7:0]       alpha;
        logic [2:0][7:0]  dst;
        logic [2:0][8:0]  blend;
        logic [15:0]      weight;
    } pbc_mid_t;

    // floor(x / 255) by reciprocal multiply
    function automatic logic [8:0] div255(input logic [16:0] x);
        logic [35:0] prod;
        prod = {19'd0, x} * {17'd0, DIV255_RECIP};
        return prod[34:26];
    endfunction

endpackage

>>> sv/pbc_blend.sv
// blend half: per-channel mode products, then divide by 255 or pass through, two stages
// depends on pbc_pkg
`timescale 1ns / 1ps

module pbc_blend import pbc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  pbc_cfg_t    cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_dst_pixel,
    input  logic [31:0] s_src_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output pbc_mid_t    m_data
);

    logic              a_valid_reg, a_valid_next;
    logic [2:0][16:0]  a_num_reg, a_num_next;
    logic [2:0][8:0]   a_pass_reg, a_pass_next;
    logic              a_div_reg, a_div_next;
    logic [31:0]       a_dst_reg;
    logic [15:0]       a_weight_reg, a_weight_next;
    logic              a_ready;

    logic              b_valid_reg, b_valid_next;
    pbc_mid_t          b_data_reg, b_data_next;
    logic              b_ready;

    // a stage takes an item when empty or when its item moves on
    assign b_ready = !b_valid_reg || m_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;

    // stage a: mode products and source weight
    always_comb begin
        logic [7:0]  d, s, nd, ns;
        logic [15:0] ds, ndns;
        a_valid_next  = a_ready ? s_valid : a_valid_reg;
        a_weight_next = 16'({9'd0, s_src_pixel[31:24]} * {8'd0, cfg.opacity});
        a_div_next    = 1'b1;
        for (int c = 0; c < 3; c++) begin
            d    = s_dst_pixel[8*c +: 8];
            s    = s_src_pixel[8*c +: 8];
            nd   = 8'd255 - d;
            ns   = 8'd255 - s;
            ds   = {8'd0, d} * {8'd0, s};
            ndns = {8'd0, nd} * {8'd0, ns};
            a_num_next[c]  = {1'b0, ds};
            a_pass_next[c] = {1'b0, s};
            case (cfg.blend_mode)
                MODE_MULTIPLY: begin
                    a_num_next[c] = {1'b0, ds};
                end
                MODE_SCREEN: begin
                    a_num_next[c] = FULL_SQ - {1'b0, ndns};
                end
                MODE_OVERLAY: begin
                    if (!d[7]) begin
                        a_num_next[c] = {ds, 1'b0};
                    end else begin
                        a_num_next[c] = FULL_SQ - {ndns, 1'b0};
                    end
                end
                MODE_ADD: begin
                    a_pass_next[c] = {1'b0, d} + {1'b0, s};
                end
                default: begin
                    a_pass_next[c] = {1'b0, s};
                end
            endcase
        end
        case (cfg.blend_mode)
            MODE_MULTIPLY, MODE_SCREEN, MODE_OVERLAY: a_div_next = 1'b1;
            default:                                  a_div_next = 1'b0;
        endcase
    end

    // stage b: divide by 255 or pass through
    always_comb begin
        b_valid_next      = b_ready ? a_valid_reg : b_valid_reg;
        b_data_next.alpha  = a_dst_reg[31:24];
        b_data_next.weight = a_weight_reg;
        for (int c = 0; c < 3; c++) begin
            b_data_next.dst[c]   = a_dst_reg[8*c +: 8];
            b_data_next.blend[c] = a_div_reg ? div255(a_num_reg[c]) : a_pass_reg[c];
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_num_reg    <= a_num_next;
            a_pass_reg   <= a_pass_next;
            a_div_reg    <= a_div_next;
            a_dst_reg    <= s_dst_pixel;
            a_weight_reg <= a_weight_next;
        end
        if (b_ready) begin
            b_data_reg <= b_data_next;
        end
    end

    assign m_valid = b_valid_reg;
    assign m_data  = b_data_reg;

endmodule

>>> sv/pbc_mix.sv
// mix half: weighted sum with the destination, then divide by 65280 and clamp
// depends on pbc_pkg
`timescale 1ns / 1ps

module pbc_mix import pbc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pbc_mid_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_pixel
);

    logic              c_valid_reg, c_valid_next;
    logic [2:0][24:0]  c_num_reg, c_num_next;
    logic [7:0]        c_alpha_reg;
    logic              c_ready;

    logic              d_valid_reg, d_valid_next;
    logic [31:0]       d_pixel_reg, d_pixel_next;
    logic              d_ready;

    assign d_ready = !d_valid_reg || m_ready;
    assign c_ready = !c_valid_reg || d_ready;
    assign s_ready = c_ready;

    // stage c: d*(one-w) + b*w per channel
    always_comb begin
        logic [15:0] inv_w;
        logic [24:0] pd, pb;
        c_valid_next = c_ready ? s_valid : c_valid_reg;
        inv_w        = MIX_ONE - s_data.weight;
        for (int c = 0; c < 3; c++) begin
            pd = 25'({17'd0, s_data.dst[c]} * {9'd0, inv_w});
            pb = 25'({16'd0, s_data.blend[c]} * {9'd0, s_data.weight});
            c_num_next[c] = pd + pb;
        end
    end

    // stage d: divide by 256 then by 255, clamp at 255
    always_comb begin
        logic [8:0] q;
        d_valid_next        = d_ready ? c_valid_reg : d_valid_reg;
        d_pixel_next[31:24] = c_alpha_reg;
        for (int c = 0; c < 3; c++) begin
            q = div255(c_num_reg[c][24:8]);
            d_pixel_next[8*c +: 8] = q[8] ? 8'd255 : q[7:0];
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (c_ready) begin
            c_num_reg   <= c_num_next;
            c_alpha_reg <= s_data.alpha;
        end
        if (d_ready) begin
            d_pixel_reg <= d_pixel_next;
        end
    end

    assign m_valid     = d_valid_reg;
    assign m_out_pixel = d_pixel_reg;

endmodule

>>> sv/pixel_blend_composite_top.sv
// Pixel blend compositor, top level.
// Input channel s_*: one destination and one source ARGB8888 pixel per item.
// Output channel m_*: one blended pixel per item, alpha taken from the
// destination, red, green and blue blended in the configured mode and mixed
// with the destination by weight src_alpha*opacity, clamped at 255.
// Configuration: cfg_wr_en with cfg_index 0 writes blend_mode (0 normal,
// 1 multiply, 2 screen, 3 overlay, 4 add, others normal), index 1 writes
// opacity (256 is opaque, larger values clamp to 256). Other indexes are
// ignored. Write only while no item is in flight.
// Throughput: one item per clock while m_ready is high. The accepting edge
// loads the first of four register stages (products, divide by 255, weighted
// sum, divide by 65280 and clamp); m_valid is the last stage's valid bit.
// Each stage is ready when empty or when its item moves on, so when the
// receiver stalls, items keep entering until every stage holds one; nothing
// is dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and sets
// blend_mode to normal and opacity to 256.
// depends on pbc_pkg, pbc_blend, pbc_mix and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pixel_blend_composite_top import pbc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [8:0]             cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [31:0]            s_dst_pixel,
    input  logic [31:0]            s_src_pixel,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_out_pixel
);

    pbc_cfg_t cfg_reg, cfg_next;
    logic     mid_valid;
    logic     mid_ready;
    pbc_mid_t mid_data;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IDX_MODE: begin
                    cfg_next.blend_mode = cfg_wdata[2:0];
                end
                CFG_IDX_OPACITY: begin
                    cfg_next.opacity = (cfg_wdata > OPACITY_ONE) ? OPACITY_ONE : cfg_wdata;
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blend_mode <= MODE_NORMAL;
            cfg_reg.opacity    <= OPACITY_ONE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // blend half
    pbc_blend u_blend (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_dst_pixel (s_dst_pixel),
        .s_src_pixel (s_src_pixel),
        .m_valid     (mid_valid),
        .m_ready     (mid_ready),
        .m_data      (mid_data)
    );

    // mix half
    pbc_mix u_mix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (mid_valid),
        .s_ready     (mid_ready),
        .s_data      (mid_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_pixel (m_out_pixel)
    );

    // checks
    `ASSERT_ALWAYS(a_opacity_range, aclk, aresetn, cfg_reg.opacity <= OPACITY_ONE, "opacity above one")
    `ASSERT_NEXT(a_mid_hold, aclk, aresetn, mid_valid && !mid_ready, mid_valid && $stable(mid_data), "mid item changed while stalled")
    `ASSERT_NEXT_RAW(a_reset_empty, aclk, !aresetn, !m_valid, "output valid right after reset")

endmodule

>>> sim/testbench.sv
// self-checking testbench for pixel_blend_composite_top: directed and random pixel pairs
// under all modes, corner and random opacities, checked against a built-in blend predictor
// depends on pbc_pkg and the pixel_blend_composite_top rtl
`timescale 1ns / 1ps

module testbench;
    import pbc_pkg::*;

    localparam int RESET_CYCLES   = 4;
    localparam int PIPE_LATENCY   = 4;
    localparam int STALL_LIMIT    = 5000;
    localparam int LONG_HOLD      = 150;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 60;
    localparam int LONG_HOLD_PHASE = 4;
    localparam int IDLE_HEAVY     = 71;
    localparam int IDLE_LIGHT     = 16;
    localparam int REPORT_LIMIT   = 10;

    // arithmetic constants of the blend
    localparam int unsigned CHAN_MAX      = 255;
    localparam int unsigned FULL_SQUARE   = 65025;
    localparam int unsigned MIX_FULL      = 65280;
    localparam int unsigned OPACITY_FULL  = 256;
    localparam int unsigned OVERLAY_SPLIT = 128;

    // codes outside the defined sets
    localparam logic [2:0] MODE_UNUSED_TOP = 3'd7;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
    localparam logic [8:0] OPACITY_OVER_MAX = 9'd511;

    typedef struct {
        logic [31:0] dst;
        logic [31:0] src;
    } pixel_pair_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [8:0]             cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [31:0]            s_dst_pixel = '0;
    logic [31:0]            s_src_pixel = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [31:0]            m_out_pixel;

    pixel_pair_t pixel_queue[$];
    logic [31:0] expected_pixels[$];

    // configuration as written to the block; opacity is clamped in the predictor
    logic [2:0] cur_mode = MODE_NORMAL;
    logic [8:0] cur_opacity = OPACITY_ONE;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    logic [2:0] directed_modes [6] = '{MODE_NORMAL, MODE_MULTIPLY, MODE_SCREEN,
                                       MODE_OVERLAY, MODE_ADD, MODE_UNUSED_TOP};
    logic [8:0] opacity_corners [7] = '{9'd0, 9'd1, 9'd128, 9'd255, 9'd256, 9'd257,
                                        OPACITY_OVER_MAX};

    pixel_blend_composite_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_dst_pixel (s_dst_pixel),
        .s_src_pixel (s_src_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_pixel (m_out_pixel)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // blend each color channel, mix it with the destination, keep destination alpha
    function automatic logic [31:0] predict_composite(input logic [31:0] dst,
                                                      input logic [31:0] src,
                                                      input logic [2:0] mode,
                                                      input logic [8:0] opac);
        int unsigned op, w, d, s, nd, ns, b, mixed;
        int ch;
        logic [31:0] res;
        op = (opac > OPACITY_FULL) ? OPACITY_FULL : 32'(opac);
        w = 32'(src[31:24]) * op;
        res = {dst[31:24], 24'd0};
        for (ch = 0; ch < 3; ch++) begin
            d = 32'(dst[8*ch +: 8]);
            s = 32'(src[8*ch +: 8]);
            nd = CHAN_MAX - d;
            ns = CHAN_MAX - s;
            case (mode)
                MODE_MULTIPLY: b = (d * s) / CHAN_MAX;
                MODE_SCREEN:   b = (FULL_SQUARE - nd * ns) / CHAN_MAX;
                MODE_OVERLAY: begin
                    if (d < OVERLAY_SPLIT)
                        b = (2 * d * s) / CHAN_MAX;
                    else
                        b = (FULL_SQUARE - 2 * nd * ns) / CHAN_MAX;
                end
                MODE_ADD:      b = d + s;
                default:       b = s;
            endcase
            mixed = (d * (MIX_FULL - w) + b * w) / MIX_FULL;
            if (mixed > CHAN_MAX)
                mixed = CHAN_MAX;
            res[8*ch +: 8] = mixed[7:0];
        end
        return res;
    endfunction

    // byte biased toward the channel corners and the overlay split
    function automatic logic [7:0] corner_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] gen_pixel();
        if ($urandom_range(0, 1) == 0)
            return $urandom;
        return {corner_byte(), corner_byte(), corner_byte(), corner_byte()};
    endfunction

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [8:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_IDX_MODE:    cur_mode = val[2:0];
            CFG_IDX_OPACITY: cur_opacity = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // hold the sender until every expected pixel is back
    task automatic wait_drained();
        while (pixel_queue.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    // driver: offers queued pairs, predicts on acceptance
    always @(posedge aclk) begin
        pixel_pair_t pair;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_dst_pixel <= '0;
            s_src_pixel <= '0;
        end else begin
            if (s_valid && s_ready)
                expected_pixels.push_back(predict_composite(s_dst_pixel, s_src_pixel,
                                                            cur_mode, cur_opacity));
            if (!s_valid || s_ready) begin
                if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    pair = pixel_queue.pop_front();
                    s_valid <= 1'b1;
                    s_dst_pixel <= pair.dst;
                    s_src_pixel <= pair.src;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure, with a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: compare each accepted item with the oldest prediction
    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected output item: out_pixel %h", m_out_pixel);
            end else begin
                want = expected_pixels.pop_front();
                if (m_out_pixel !== want) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("out_pixel mismatch: expected %h got %h", want, m_out_pixel);
                end
            end
        end
    end

    // watchdog on cycles with no progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("pixel_blend_composite_top test failed");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial begin
        int p, m, k;
        logic [2:0] mode_sel;
        logic [8:0] opac_sel;
        logic [5:0] pad;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners under every mode, first one on reset settings
        for (m = 0; m < 6; m++) begin
            if (m > 0)
                cfg_write(CFG_IDX_MODE, {6'd0, directed_modes[m]});
            if (directed_modes[m] == MODE_UNUSED_TOP)
                cfg_write(CFG_IDX_OPACITY, OPACITY_OVER_MAX);
            pixel_queue.push_back('{32'h00000000, 32'hFFFFFFFF});
            pixel_queue.push_back('{32'hFFFFFFFF, 32'h00000000});
            pixel_queue.push_back('{32'hA5807F80, 32'hFF7F80FF});
            pixel_queue.push_back('{32'h5AFFC001, 32'hFFFF40FE});
            wait_drained();
        end

        // random phases over modes, opacities and idling profiles
        for (p = 0; p < RANDOM_PHASES; p++) begin
            mode_sel = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
            opac_sel = (p < 7) ? opacity_corners[p] : 9'($urandom_range(0, 511));
            pad = 6'($urandom);
            if (p % 4 == 1) begin
                // writes to unmapped indexes must leave the settings alone
                cfg_write(CFG_IDX_SPARE_A, 9'($urandom));
                cfg_write(CFG_IDX_SPARE_B, 9'($urandom));
            end
            if (p % 2 == 0) begin
                cfg_write(CFG_IDX_MODE, {pad, mode_sel});
                cfg_write(CFG_IDX_OPACITY, opac_sel);
            end else begin
                cfg_write(CFG_IDX_OPACITY, opac_sel);
                cfg_write(CFG_IDX_MODE, {pad, mode_sel});
            end
            case (p % 4)
                0: begin send_idle_pct = 0;          recv_stall_pct = 0;          end
                1: begin send_idle_pct = IDLE_HEAVY; recv_stall_pct = 0;          end
                2: begin send_idle_pct = 0;          recv_stall_pct = IDLE_HEAVY; end
                default: begin send_idle_pct = IDLE_LIGHT; recv_stall_pct = IDLE_LIGHT; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++)
                pixel_queue.push_back('{gen_pixel(), gen_pixel()});
            if (p == LONG_HOLD_PHASE)
                hold_requests++;
            wait_drained();
        end

        if (error_count == 0)
            $display("pixel_blend_composite_top test passed");
        else
            $display("pixel_blend_composite_top test failed");
        $finish;
    end

endmodule
